// ----- rtl/bold_signal_observation_defines.svh -----
// Assertion macros shared by the BOLD observation RTL.
`ifndef BOLD_SIGNAL_OBSERVATION_DEFINES_SVH
`define BOLD_SIGNAL_OBSERVATION_DEFINES_SVH
`ifndef SYNTHESIS
`define BSO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define BSO_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define BSO_ASSERT(label, prop, msg)
`define BSO_ASSERT_NORST(label, prop, msg)
`endif
`endif

// ----- rtl/bso_pkg.sv -----
// Shared constants and types of the BOLD observation pipeline.
`timescale 1ns / 1ps
package bso_pkg;
    localparam int INPUT_FRAC_BITS = 12;
    localparam int FIELD_W = 15;
    localparam int ARG_W = FIELD_W + 2;
    localparam int A_W = 48;
    localparam int N_W = 8;
    localparam int RQ_W = 30;
    localparam int TERM_W = 31;
    localparam int SUM_W = 32;
    localparam int TAYLOR_TERMS = 14;
    localparam int EXP_W = 52;
    localparam int PROD_W = 2 * EXP_W;
    localparam int VAL_W = 56;
    localparam int RES_W = VAL_W + 6;
    localparam int OUT_W = 32;
    localparam int RED_SHIFT = 20;
    localparam int EST_SHIFT = 26;
    localparam int EXP_LAT = 4 + 3 * TAYLOR_TERMS;
    localparam int MUL_LAT = 3;
    localparam int COMB_LAT = 2;
    localparam int PIPE_LAT = EXP_LAT + 2 * MUL_LAT + COMB_LAT;

    localparam logic [EXP_W-1:0] LN2_Q32 = EXP_W'(64'd2977044472);
    localparam logic signed [A_W-1:0] EXP_LIMIT_Q32 = A_W'(64'sd51539607552);
    localparam logic [15:0] INV_LN2_Q14 = 16'd23637;
    localparam logic [EXP_W-1:0] K1_Q32 = EXP_W'(64'd11908398124);
    localparam logic [EXP_W-1:0] K04_Q32 = EXP_W'(64'd1717986918);
    localparam logic [EXP_W-1:0] K06_Q32 = EXP_W'(64'd2576980378);
    localparam logic [VAL_W-1:0] K_POS_Q16 =
        VAL_W'((64'd11908398124 + 64'd4294967296) >> 16);

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;
endpackage

// ----- rtl/bso_exp.sv -----
// Pipelined exponential: range reduction by ln2, fourteen-term Taylor series, final shift.
`timescale 1ns / 1ps
module bso_exp (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [bso_pkg::ARG_W-1:0]     i_arg,
    output logic        [bso_pkg::EXP_W-1:0]     o_res
);
    localparam int T = bso_pkg::TAYLOR_TERMS;

    logic signed [bso_pkg::A_W-1:0] a_full;
    logic signed [bso_pkg::A_W-1:0] a_clip;
    logic signed [17:0]             a_top;
    logic signed [34:0]             est_p;
    logic signed [bso_pkg::A_W-1:0] r_a;
    logic signed [bso_pkg::N_W-1:0] r_ne;
    logic signed [40:0]             back_p;
    logic signed [bso_pkg::A_W-1:0] r_r1;
    logic signed [bso_pkg::N_W-1:0] r_n1;
    logic [bso_pkg::RQ_W-1:0]       r_rq;
    logic signed [bso_pkg::N_W-1:0] r_n2;
    logic signed [bso_pkg::A_W-1:0] n_r2;
    logic signed [bso_pkg::N_W-1:0] n_n2;
    logic signed [bso_pkg::A_W-1:0] ln2_s;

    logic [bso_pkg::TERM_W-1:0]     w_term [0:T];
    logic [bso_pkg::SUM_W-1:0]      w_sum  [0:T];
    logic [bso_pkg::RQ_W-1:0]       w_rq   [0:T];
    logic signed [bso_pkg::N_W-1:0] w_n    [0:T];

    logic signed [bso_pkg::N_W:0]   sh;
    logic signed [bso_pkg::N_W:0]   neg_sh;
    logic [bso_pkg::EXP_W-1:0]      n_res;
    logic [bso_pkg::EXP_W-1:0]      r_res;

    assign a_full = bso_pkg::A_W'(i_arg) <<< (32 - bso_pkg::INPUT_FRAC_BITS);
    assign ln2_s  = $signed(bso_pkg::LN2_Q32[bso_pkg::A_W-1:0]);

    always_comb begin
        if (a_full > bso_pkg::EXP_LIMIT_Q32) begin
            a_clip = bso_pkg::EXP_LIMIT_Q32;
        end else if (a_full < -bso_pkg::EXP_LIMIT_Q32) begin
            a_clip = -bso_pkg::EXP_LIMIT_Q32;
        end else begin
            a_clip = a_full;
        end
    end

    // Estimate of floor(a / ln2) from the top bits; it is off by at most one.
    assign a_top  = 18'(a_clip >>> bso_pkg::RED_SHIFT);
    assign est_p  = a_top * $signed({1'b0, bso_pkg::INV_LN2_Q14});
    assign back_p = r_ne * $signed({1'b0, bso_pkg::LN2_Q32[31:0]});

    always_comb begin
        if (r_r1 < 0) begin
            n_r2 = r_r1 + ln2_s;
            n_n2 = r_n1 - bso_pkg::N_W'(1);
        end else if (r_r1 >= ln2_s) begin
            n_r2 = r_r1 - ln2_s;
            n_n2 = r_n1 + bso_pkg::N_W'(1);
        end else begin
            n_r2 = r_r1;
            n_n2 = r_n1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= a_clip;
            r_ne <= bso_pkg::N_W'(est_p >>> bso_pkg::EST_SHIFT);
            r_r1 <= r_a - bso_pkg::A_W'(back_p);
            r_n1 <= r_ne;
            r_rq <= n_r2[31:2];
            r_n2 <= n_n2;
        end
    end

    assign w_term[0] = bso_pkg::TERM_W'(1) << 30;
    assign w_sum[0]  = bso_pkg::SUM_W'(1) << 30;
    assign w_rq[0]   = r_rq;
    assign w_n[0]    = r_n2;

    // Each term takes three stages: product with r, reciprocal multiply, remainder fix-up.
    for (genvar k = 1; k <= T; k++) begin : g_term
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / k);
        localparam logic [bso_pkg::TERM_W-1:0] KC = bso_pkg::TERM_W'(k);

        logic [60:0]                    prod_a;
        logic [63:0]                    prod_b;
        logic [bso_pkg::TERM_W+3:0]     back;
        logic [bso_pkg::TERM_W+3:0]     rem;
        logic [bso_pkg::TERM_W-1:0]     term;
        logic [bso_pkg::TERM_W-1:0]     r_pa, r_pb, r_qe, r_tc;
        logic [bso_pkg::SUM_W-1:0]      r_sa, r_sb, r_sc;
        logic [bso_pkg::RQ_W-1:0]       r_rqa, r_rqb, r_rqc;
        logic signed [bso_pkg::N_W-1:0] r_na, r_nb, r_nc;

        assign prod_a = 61'(w_term[k-1]) * 61'(w_rq[k-1]);
        assign prod_b = 64'(r_pa) * 64'(RECIP);
        assign back   = (bso_pkg::TERM_W+4)'(r_qe) * (bso_pkg::TERM_W+4)'(KC);
        assign rem    = (bso_pkg::TERM_W+4)'(r_pb) - back;
        assign term   = r_qe + bso_pkg::TERM_W'(rem >= (bso_pkg::TERM_W+4)'(KC));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa  <= prod_a[30 +: bso_pkg::TERM_W];
                r_sa  <= w_sum[k-1];
                r_rqa <= w_rq[k-1];
                r_na  <= w_n[k-1];
                r_qe  <= prod_b[32 +: bso_pkg::TERM_W];
                r_pb  <= r_pa;
                r_sb  <= r_sa;
                r_rqb <= r_rqa;
                r_nb  <= r_na;
                r_tc  <= term;
                r_sc  <= r_sb + bso_pkg::SUM_W'(term);
                r_rqc <= r_rqb;
                r_nc  <= r_nb;
            end
        end

        assign w_term[k] = r_tc;
        assign w_sum[k]  = r_sc;
        assign w_rq[k]   = r_rqc;
        assign w_n[k]    = r_nc;
    end

    assign sh     = (bso_pkg::N_W+1)'(w_n[T]) + (bso_pkg::N_W+1)'(2);
    assign neg_sh = -sh;

    always_comb begin
        if (!sh[bso_pkg::N_W]) begin
            n_res = bso_pkg::EXP_W'(w_sum[T]) << sh[4:0];
        end else begin
            n_res = bso_pkg::EXP_W'(w_sum[T] >> neg_sh[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

// ----- rtl/bso_mul.sv -----
// Three-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps
module bso_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bso_pkg::EXP_W-1:0]     i_a,
    input  logic [bso_pkg::EXP_W-1:0]     i_b,
    output logic [bso_pkg::PROD_W-1:0]    o_prod
);
    localparam int H = bso_pkg::EXP_W / 2;

    logic [2*H-1:0]              r_ll, r_lh, r_hl, r_hh;
    logic [2*H-1:0]              r_ll2, r_hh2;
    logic [2*H:0]                r_mid;
    logic [bso_pkg::PROD_W-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll   <= i_a[H-1:0] * i_b[H-1:0];
            r_lh   <= i_a[H-1:0] * i_b[2*H-1:H];
            r_hl   <= i_a[2*H-1:H] * i_b[H-1:0];
            r_hh   <= i_a[2*H-1:H] * i_b[2*H-1:H];
            r_mid  <= (2*H+1)'(r_lh) + (2*H+1)'(r_hl);
            r_ll2  <= r_ll;
            r_hh2  <= r_hh;
            r_prod <= bso_pkg::PROD_W'(r_ll2) + (bso_pkg::PROD_W'(r_mid) << H)
                    + (bso_pkg::PROD_W'(r_hh2) << (2 * H));
        end
    end

    assign o_prod = r_prod;
endmodule

// ----- rtl/bold_signal_observation.sv -----
// BOLD observation equation: one region word in, one signal word out.
// Each word passes through the exp series, two multiplies and the sums to reach the output.
// Throughput: one word per cycle while the skid register is empty; the Taylor chain of the exp unit sets the depth.
// A two-entry output stage (register and skid) keeps input ready while one result waits.
// Reset (synchronous, active low) empties the pipeline and sets log_signal_ratio to zero.
`timescale 1ns / 1ps
`include "bold_signal_observation_defines.svh"
module bold_signal_observation (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [14:0]          i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // log_volume [14:0], log_deoxy [29:15]
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // bold_signal [31:0]
    output logic [0:0]           m_axis_tuser,  // saturated [0]
    output logic                 m_axis_tlast
);
    localparam int L = bso_pkg::PIPE_LAT;
    localparam int VW = bso_pkg::VAL_W;
    localparam int EW = bso_pkg::EXP_W;

    logic [bso_pkg::FIELD_W-1:0]       r_cfg;
    logic                              en;
    bso_pkg::t_tag                     r_tag [0:L-1];
    logic signed [bso_pkg::ARG_W-1:0]  lv, lq, ld, le;
    logic [EW-1:0]                     ex_v, ex_q, ex_r, ex_e;
    logic [bso_pkg::PROD_W-1:0]        m_k2, m_pev, m_p06, m_pkq, m_pr;
    logic [EW-1:0]                     r_v_dl [0:5];
    logic [EW-1:0]                     r_r_dl [0:2];
    logic [VW-1:0]                     r_pev_dl [0:2];
    logic [VW-1:0]                     r_p06_dl [0:2];
    logic [VW-1:0]                     r_pkq_dl [0:2];
    logic [VW:0]                       r_pos, r_n1, r_n2;
    logic signed [bso_pkg::RES_W-1:0]  r_d;
    logic signed [bso_pkg::RES_W-1:0]  g;
    logic [bso_pkg::OUT_W-1:0]         n_bold;
    logic                              n_sat;
    logic                              exit_v;
    logic                              r_ov, r_sk_v;
    logic [bso_pkg::OUT_W+1:0]         r_out, r_skid, n_word;

    localparam logic signed [bso_pkg::RES_W-1:0] SAT_HI = bso_pkg::RES_W'(64'sd2147483647);
    localparam logic signed [bso_pkg::RES_W-1:0] SAT_LO = bso_pkg::RES_W'(-64'sd2147483648);

    assign en            = !r_sk_v;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    assign lv = bso_pkg::ARG_W'($signed(s_axis_tdata[14:0]));
    assign lq = bso_pkg::ARG_W'($signed(s_axis_tdata[29:15]));
    assign ld = lq - lv;
    assign le = bso_pkg::ARG_W'($signed(r_cfg));

    bso_exp u_exp_v (.i_clk(i_clk), .i_en(en), .i_arg(lv), .o_res(ex_v));
    bso_exp u_exp_q (.i_clk(i_clk), .i_en(en), .i_arg(lq), .o_res(ex_q));
    bso_exp u_exp_r (.i_clk(i_clk), .i_en(en), .i_arg(ld), .o_res(ex_r));
    bso_exp u_exp_e (.i_clk(i_clk), .i_en(en), .i_arg(le), .o_res(ex_e));

    bso_mul u_mul_k2  (.i_clk(i_clk), .i_en(en), .i_a(bso_pkg::K04_Q32), .i_b(ex_e),
                       .o_prod(m_k2));
    bso_mul u_mul_pev (.i_clk(i_clk), .i_en(en), .i_a(ex_e), .i_b(ex_v), .o_prod(m_pev));
    bso_mul u_mul_p06 (.i_clk(i_clk), .i_en(en), .i_a(bso_pkg::K06_Q32), .i_b(ex_e),
                       .o_prod(m_p06));
    bso_mul u_mul_pkq (.i_clk(i_clk), .i_en(en), .i_a(bso_pkg::K1_Q32), .i_b(ex_q),
                       .o_prod(m_pkq));
    // The k2 gain depends on ep, so its product with q/v runs one multiply later.
    bso_mul u_mul_pr  (.i_clk(i_clk), .i_en(en), .i_a(m_k2[32 +: EW]), .i_b(r_r_dl[2]),
                       .o_prod(m_pr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) begin
                r_tag[i].valid <= 1'b0;
            end
        end else if (en) begin
            r_tag[0].valid <= s_axis_tvalid;
            for (int i = 1; i < L; i++) begin
                r_tag[i].valid <= r_tag[i-1].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0].last <= s_axis_tlast;
            for (int i = 1; i < L; i++) begin
                r_tag[i].last <= r_tag[i-1].last;
            end
            r_v_dl[0]   <= ex_v;
            for (int i = 1; i < 6; i++) begin
                r_v_dl[i] <= r_v_dl[i-1];
            end
            r_r_dl[0]   <= ex_r;
            r_pev_dl[0] <= m_pev[48 +: VW];
            r_p06_dl[0] <= m_p06[48 +: VW];
            r_pkq_dl[0] <= m_pkq[48 +: VW];
            for (int i = 1; i < 3; i++) begin
                r_r_dl[i]   <= r_r_dl[i-1];
                r_pev_dl[i] <= r_pev_dl[i-1];
                r_p06_dl[i] <= r_p06_dl[i-1];
                r_pkq_dl[i] <= r_pkq_dl[i-1];
            end
            r_pos <= (VW+1)'(bso_pkg::K_POS_Q16) + (VW+1)'(r_pev_dl[2]);
            r_n1  <= (VW+1)'(r_p06_dl[2]) + (VW+1)'(r_pkq_dl[2]);
            r_n2  <= (VW+1)'(m_pr[48 +: VW]) + (VW+1)'(r_v_dl[5] >> 16);
            r_d   <= $signed(bso_pkg::RES_W'(r_pos)) - $signed(bso_pkg::RES_W'(r_n1))
                   - $signed(bso_pkg::RES_W'(r_n2));
        end
    end

    // Four times the difference, clipped to the signed Q15.16 range.
    assign g = r_d <<< 2;

    always_comb begin
        if (g > SAT_HI) begin
            n_bold = 32'h7FFF_FFFF;
            n_sat  = 1'b1;
        end else if (g < SAT_LO) begin
            n_bold = 32'h8000_0000;
            n_sat  = 1'b1;
        end else begin
            n_bold = g[bso_pkg::OUT_W-1:0];
            n_sat  = 1'b0;
        end
    end

    assign exit_v = r_tag[L-1].valid;
    assign n_word = {r_tag[L-1].last, n_sat, n_bold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (!r_ov || m_axis_tready) begin
            if (r_sk_v) begin
                r_ov   <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_ov <= exit_v;
            end
        end else if (en && exit_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || m_axis_tready) begin
            r_out <= r_sk_v ? r_skid : n_word;
        end else if (en) begin
            r_skid <= n_word;
        end
    end

    assign m_axis_tvalid   = r_ov;
    assign m_axis_tdata    = r_out[bso_pkg::OUT_W-1:0];
    assign m_axis_tuser[0] = r_out[bso_pkg::OUT_W];
    assign m_axis_tlast    = r_out[bso_pkg::OUT_W+1];

    `BSO_ASSERT(a_skid_needs_out, r_sk_v |-> r_ov, "skid word held with output empty")
    `BSO_ASSERT(a_skid_on_stall, $rose(r_sk_v) |-> $past(m_axis_tvalid && !m_axis_tready), "skid filled without stall")
    `BSO_ASSERT(a_sat_clips, m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == 32'h7FFFFFFF || m_axis_tdata == 32'h80000000), "saturated word not at a range limit")
    `BSO_ASSERT_NORST(a_reset_empties, !i_rst_n |=> !r_ov && !r_sk_v, "output stage not empty after reset")
endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the BOLD observation pipeline, with its own arithmetic predictor.
`timescale 1ns / 1ps
module tb;
    localparam longint unsigned LN2_C  = 64'd2977044472;
    localparam longint unsigned K1_C   = 64'd11908398124;
    localparam longint unsigned ONE_C  = 64'd4294967296;
    localparam longint unsigned K04_C  = 64'd1717986918;
    localparam longint unsigned K06_C  = 64'd2576980378;
    localparam int              DRAIN  = 80;
    localparam longint          CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [14:0] lv;
        logic [14:0] lq;
        logic        last;
        logic        known;
        logic [31:0] bold;
        logic        sat;
    } t_row;

    typedef struct {
        logic [31:0] bold;
        logic        sat;
        logic        last;
    } t_signal;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [14:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // log_volume [14:0], log_deoxy [29:15]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // bold_signal [31:0]
    logic [0:0]  m_axis_tuser;       // saturated [0]
    logic        m_axis_tlast;

    logic [14:0] signal_ratio_log = '0;
    t_signal     pending_signals[$];
    int          n_errors = 0;
    longint      n_cycles = 0;
    bit          rx_enable = 1'b0;

    bold_signal_observation u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // floor(a*b / 2^s) on the exact 128-bit product.
    function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                  int s);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >> s);
    endfunction

    // Exponential of a signed Q2.12 argument, result unsigned Q.32.
    function automatic longint unsigned exp_q32(longint arg);
        longint lim;
        longint a;
        longint n;
        longint r;
        longint unsigned rq;
        longint unsigned term;
        longint unsigned acc;
        int sh;
        lim = 64'sd12 * longint'(ONE_C);
        a = arg * (64'sd1 <<< (32 - bso_pkg::INPUT_FRAC_BITS));
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        n = a / longint'(LN2_C);
        if (a < 0 && n * longint'(LN2_C) != a) n = n - 1;
        r = a - n * longint'(LN2_C);
        rq = longint'(r) >> 2;
        term = 64'd1 << 30;
        acc = term;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * rq) >> 30) / longint'(k);
            acc = acc + term;
        end
        sh = int'(n) + 2;
        if (sh >= 0) return acc << sh;
        return acc >> (-sh);
    endfunction

    function automatic t_signal predict_bold(logic [14:0] lv_bits, logic [14:0] lq_bits,
                                             logic last);
        longint lv;
        longint lq;
        longint unsigned v;
        longint unsigned q;
        longint unsigned rt;
        longint unsigned ep;
        longint unsigned k2;
        longint unsigned pos;
        longint unsigned neg;
        longint g;
        t_signal res;
        lv = longint'($signed(lv_bits));
        lq = longint'($signed(lq_bits));
        v = exp_q32(lv);
        q = exp_q32(lq);
        rt = exp_q32(lq - lv);
        ep = exp_q32(longint'($signed(signal_ratio_log)));
        k2 = mul_shift(K04_C, ep, 32);
        pos = ((K1_C + ONE_C) >> 16) + mul_shift(ep, v, 48);
        neg = mul_shift(K06_C, ep, 48) + mul_shift(K1_C, q, 48) + mul_shift(k2, rt, 48)
            + (v >> 16);
        g = (longint'(pos) - longint'(neg)) * 4;
        res.sat = 1'b0;
        if (g > 64'sd2147483647) begin
            g = 64'sd2147483647;
            res.sat = 1'b1;
        end else if (g < -64'sd2147483648) begin
            g = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.bold = g[31:0];
        res.last = last;
        return res;
    endfunction

    // Receiving side: random stalls between words, checked against the oldest expectation.
    initial begin
        int gap;
        t_signal want;
        forever begin
            @(posedge i_clk);
            if (rx_enable) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                do @(posedge i_clk); while (!m_axis_tvalid);
                m_axis_tready <= 1'b0;
                if (pending_signals.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("Unexpected word: %h", m_axis_tdata);
                end else begin
                    want = pending_signals.pop_front();
                    if (m_axis_tdata !== want.bold || m_axis_tuser[0] !== want.sat ||
                        m_axis_tlast !== want.last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("Mismatch: expected %h sat %b last %b, got %h sat %b last %b",
                                     want.bold, want.sat, want.last, m_axis_tdata,
                                     m_axis_tuser[0], m_axis_tlast);
                    end
                end
            end
        end
    end

    task automatic send_region(logic [14:0] lv, logic [14:0] lq, logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, lq, lv};
        s_axis_tlast <= last;
        pending_signals.push_back(predict_bold(lv, lq, last));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle_and_write(logic [14:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_signals.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        signal_ratio_log = value;
    endtask

    // Mostly ordinary physiological range, sometimes anywhere in the field.
    function automatic logic [14:0] draw_log();
        if ($urandom_range(0, 3) == 0) return 15'($urandom);
        return 15'($signed($urandom_range(0, 4096)) - 2048);
    endfunction

    initial begin
        t_row rows[$];
        t_signal guess;
        logic [14:0] ratios[6];
        ratios = '{15'h4000, 15'h3fff, 15'h7000, 15'h0800, 15'h7c00, 15'h0000};

        // Baseline: zero logs give v = q = 1, leaving only the truncation residue of four.
        rows.push_back('{15'h0000, 15'h0000, 1'b0, 1'b1, 32'h4, 1'b0});
        rows.push_back('{15'h3fff, 15'h3fff, 1'b1, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h4000, 15'h4000, 1'b0, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h3fff, 15'h4000, 1'b1, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h4000, 15'h3fff, 1'b0, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h0000, 15'h3fff, 1'b1, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h3fff, 15'h0000, 1'b0, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h0000, 15'h4000, 1'b0, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h4000, 15'h0000, 1'b1, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h0b17, 15'h0b17, 1'b0, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h74e9, 15'h74e9, 1'b1, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h0001, 15'h7fff, 1'b0, 1'b0, 32'h0, 1'b0});
        rows.push_back('{15'h5555, 15'h2aaa, 1'b1, 1'b0, 32'h0, 1'b0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_enable = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].known) begin
                guess = predict_bold(rows[i].lv, rows[i].lq, rows[i].last);
                if (guess.bold !== rows[i].bold || guess.sat !== rows[i].sat) begin
                    n_errors++;
                    $display("Predictor disagrees on baseline row: %h", guess.bold);
                end
            end
            send_region(rows[i].lv, rows[i].lq, rows[i].last);
        end

        // The same extremes under each signal ratio setting, then random regions.
        foreach (ratios[r]) begin
            settle_and_write(ratios[r]);
            for (int i = 0; i < 4; i++)
                send_region(rows[i + 1].lv, rows[i + 1].lq, rows[i + 1].last);
            for (int i = 0; i < 120; i++)
                send_region(draw_log(), draw_log(), $urandom_range(0, 7) == 0);
        end
        settle_and_write(15'($urandom));
        for (int i = 0; i < 15; i++)
            send_region(draw_log(), draw_log(), 1'($urandom));

        s_axis_tvalid <= 1'b0;
        while (pending_signals.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bso_pkg.sv
rtl/bso_exp.sv
rtl/bso_mul.sv
rtl/bold_signal_observation.sv
tb/sv/tb.sv
